FILE: hdl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants for the best-fit free-list allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ADDR_BITS   = 16;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RECLAIM = 2'd2;
    localparam logic [1:0] OP_RSVD    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_REQ  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ASCAN,
        S_AEND,
        S_SHIFT,
        S_SRT_RDI,
        S_SRT_KEY,
        S_SRT_CMP,
        S_SRT_PUT,
        S_MRG_RD0,
        S_MRG_C0,
        S_MRG_CMP,
        S_MRG_FIN
    } t_state;

endpackage

FILE: hdl/best_fit_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_top
// Best-fit allocator over a table of free areas held in a synchronous memory.
// Free is handled from idle; allocate scans every entry and, when an exact fit
// at entry k is removed, shifts the entries above it down; reclaim sorts by base, then merges.
// One transaction at a time; the next start is taken once o_busy drops.
// Synchronous reset; after reset the S_INIT state loads entry 0 with the pool.
// Results are strobed for one cycle on o_done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_top #(
    parameter int TABLE_DEPTH = bffa_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_BITS   = bffa_pkg::DEF_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_operation,
    input  logic [ADDR_BITS:0]   i_req_size,
    input  logic [ADDR_BITS-1:0] i_area_base,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ADDR_BITS:0]   i_cfg_data,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [ADDR_BITS-1:0] o_granted_base,
    output logic [ADDR_BITS:0]   o_granted_size,
    output logic                 o_merged
);
    import bffa_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int SW = ADDR_BITS + 1;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [SW-1:0] POOL_MAX = SW'(1) << AW;
    localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);

    t_state r_state, n_state;

    logic [AW-1:0] r_mem_base [TABLE_DEPTH];
    logic [SW-1:0] r_mem_size [TABLE_DEPTH];
    logic [AW-1:0] r_rd_base;
    logic [SW-1:0] r_rd_size;

    logic          w_we;
    logic [IW-1:0] w_wa, w_ra;
    logic [AW-1:0] w_wbase;
    logic [SW-1:0] w_wsize;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_pool, n_pool;
    logic [SW-1:0] r_req, n_req;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [IW-1:0] r_pidx, n_pidx;
    logic          r_pv, n_pv;
    logic          r_found, n_found;
    logic [IW-1:0] r_best, n_best;
    logic [AW-1:0] r_bbase, n_bbase;
    logic [SW-1:0] r_bsize, n_bsize;
    logic [AW-1:0] r_key_base, n_key_base;
    logic [SW-1:0] r_key_size, n_key_size;
    logic [AW-1:0] r_cur_base, n_cur_base;
    logic [SW-1:0] r_cur_size, n_cur_size;
    logic [IW-1:0] r_w, n_w;
    logic          r_mrg, n_mrg;

    logic          r_done, n_done;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_gbase, n_gbase;
    logic [SW-1:0] r_gsize, n_gsize;
    logic          r_merged, n_merged;

    logic          w_cmd_bad, w_scan_more, w_merge_more, w_fit, w_sort_gt, w_adj;
    logic          w_last_outer, w_cfg_wr;
    logic [SW-1:0] w_cfg_val;

    assign w_cmd_bad    = (i_req_size == '0) || (i_req_size > r_pool);
    assign w_scan_more  = r_i < r_cnt;
    assign w_merge_more = r_j < r_cnt;
    assign w_fit        = (r_rd_size >= r_req) && (!r_found || (r_rd_size < r_bsize));
    assign w_sort_gt    = r_rd_base > r_key_base;
    assign w_adj        = {2'b00, r_rd_base} ==
                          ({2'b00, r_cur_base} + {1'b0, r_cur_size});
    assign w_last_outer = (r_i + CW'(1)) == r_cnt;
    assign w_cfg_wr     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_val = SW'(1);
        end else if (i_cfg_data > POOL_MAX) begin
            w_cfg_val = POOL_MAX;
        end else begin
            w_cfg_val = i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    priority if (i_operation == OP_ALLOC) begin
                        if (!w_cmd_bad && (r_cnt != '0)) n_state = S_ASCAN;
                    end else if (i_operation == OP_RECLAIM) begin
                        if (r_cnt > CW'(1)) n_state = S_SRT_RDI;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ASCAN:   if (!w_scan_more) n_state = S_AEND;
            S_AEND:    n_state = (r_found && (r_bsize == r_req)) ? S_SHIFT : S_IDLE;
            S_SHIFT:   if (!w_scan_more) n_state = S_IDLE;
            S_SRT_RDI: n_state = S_SRT_KEY;
            S_SRT_KEY: n_state = S_SRT_CMP;
            S_SRT_CMP: begin
                if (w_sort_gt) begin
                    n_state = (r_j == CW'(1)) ? S_SRT_PUT : S_SRT_CMP;
                end else begin
                    n_state = w_last_outer ? S_MRG_RD0 : S_SRT_RDI;
                end
            end
            S_SRT_PUT: n_state = w_last_outer ? S_MRG_RD0 : S_SRT_RDI;
            S_MRG_RD0: n_state = S_MRG_C0;
            S_MRG_C0:  n_state = S_MRG_CMP;
            S_MRG_CMP: if (!w_merge_more) n_state = S_MRG_FIN;
            S_MRG_FIN: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt = r_cnt;  n_pool = r_pool;  n_req = r_req;
        n_i = r_i;  n_j = r_j;  n_pidx = r_pidx;  n_pv = r_pv;
        n_found = r_found;  n_best = r_best;  n_bbase = r_bbase;  n_bsize = r_bsize;
        n_key_base = r_key_base;  n_key_size = r_key_size;
        n_cur_base = r_cur_base;  n_cur_size = r_cur_size;
        n_w = r_w;  n_mrg = r_mrg;
        n_done = 1'b0;  n_status = ST_OK;  n_gbase = '0;  n_gsize = '0;  n_merged = 1'b0;
        w_we = 1'b0;  w_wa = '0;  w_ra = '0;  w_wbase = '0;  w_wsize = '0;
        unique case (r_state)
            S_INIT: begin
                w_we = 1'b1;  w_wsize = r_pool;  n_cnt = CW'(1);
            end
            S_IDLE: begin
                if (w_cfg_wr) begin
                    n_pool = w_cfg_val;
                    w_we = 1'b1;  w_wsize = w_cfg_val;  n_cnt = CW'(1);
                end else if (i_start) begin
                    n_req = i_req_size;
                    unique case (i_operation)
                        OP_ALLOC: begin
                            if (w_cmd_bad) begin
                                n_done = 1'b1;  n_status = ST_BAD_REQ;
                            end else if (r_cnt == '0) begin
                                n_done = 1'b1;  n_status = ST_NO_FIT;
                            end else begin
                                n_i = '0;  n_pv = 1'b0;  n_found = 1'b0;
                            end
                        end
                        OP_FREE: begin
                            n_done = 1'b1;
                            if (w_cmd_bad) begin
                                n_status = ST_BAD_REQ;
                            end else if (r_cnt >= DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we = 1'b1;  w_wa = r_cnt[IW-1:0];
                                w_wbase = i_area_base;  w_wsize = i_req_size;
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        OP_RECLAIM: begin
                            if (r_cnt > CW'(1)) begin
                                n_i = CW'(1);  n_mrg = 1'b0;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;  n_status = ST_BAD_REQ;
                        end
                    endcase
                end
            end
            S_ASCAN: begin
                if (r_pv && w_fit) begin
                    n_found = 1'b1;  n_best = r_pidx;
                    n_bbase = r_rd_base;  n_bsize = r_rd_size;
                end
                n_pv = w_scan_more;
                if (w_scan_more) begin
                    w_ra = r_i[IW-1:0];  n_pidx = r_i[IW-1:0];  n_i = r_i + CW'(1);
                end
            end
            S_AEND: begin
                if (!r_found) begin
                    n_done = 1'b1;  n_status = ST_NO_FIT;
                end else if (r_bsize > r_req) begin
                    w_we = 1'b1;  w_wa = r_best;
                    w_wbase = r_bbase + r_req[AW-1:0];  w_wsize = r_bsize - r_req;
                    n_done = 1'b1;  n_gbase = r_bbase;  n_gsize = r_req;
                end else begin
                    n_i = CW'(r_best) + CW'(1);  n_pv = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_pv) begin
                    w_we = 1'b1;  w_wa = r_pidx - IW'(1);
                    w_wbase = r_rd_base;  w_wsize = r_rd_size;
                end
                n_pv = w_scan_more;
                if (w_scan_more) begin
                    w_ra = r_i[IW-1:0];  n_pidx = r_i[IW-1:0];  n_i = r_i + CW'(1);
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    n_done = 1'b1;  n_gbase = r_bbase;  n_gsize = r_req;
                end
            end
            S_SRT_RDI: begin
                w_ra = r_i[IW-1:0];
            end
            S_SRT_KEY: begin
                n_key_base = r_rd_base;  n_key_size = r_rd_size;
                n_j = r_i;  w_ra = r_i[IW-1:0] - IW'(1);
            end
            S_SRT_CMP: begin
                w_we = 1'b1;  w_wa = r_j[IW-1:0];
                if (w_sort_gt) begin
                    w_wbase = r_rd_base;  w_wsize = r_rd_size;
                    n_j = r_j - CW'(1);
                    w_ra = r_j[IW-1:0] - IW'(2);
                end else begin
                    w_wbase = r_key_base;  w_wsize = r_key_size;
                    n_i = r_i + CW'(1);
                end
            end
            S_SRT_PUT: begin
                w_we = 1'b1;  w_wa = '0;
                w_wbase = r_key_base;  w_wsize = r_key_size;
                n_i = r_i + CW'(1);
            end
            S_MRG_RD0: begin
                w_ra = '0;
            end
            S_MRG_C0: begin
                n_cur_base = r_rd_base;  n_cur_size = r_rd_size;  n_w = '0;
                w_ra = IW'(1);  n_j = CW'(2);
            end
            S_MRG_CMP: begin
                if (w_adj) begin
                    n_cur_size = r_cur_size + r_rd_size;  n_mrg = 1'b1;
                end else begin
                    w_we = 1'b1;  w_wa = r_w;
                    w_wbase = r_cur_base;  w_wsize = r_cur_size;
                    n_w = r_w + IW'(1);
                    n_cur_base = r_rd_base;  n_cur_size = r_rd_size;
                end
                if (w_merge_more) begin
                    w_ra = r_j[IW-1:0];  n_j = r_j + CW'(1);
                end
            end
            S_MRG_FIN: begin
                w_we = 1'b1;  w_wa = r_w;
                w_wbase = r_cur_base;  w_wsize = r_cur_size;
                n_cnt = CW'(r_w) + CW'(1);
                n_done = 1'b1;  n_merged = r_mrg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_base[w_wa] <= w_wbase;
            r_mem_size[w_wa] <= w_wsize;
        end
        r_rd_base <= r_mem_base[w_ra];
        r_rd_size <= r_mem_size[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_pool  <= POOL_MAX;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pool  <= n_pool;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;  r_i <= n_i;  r_j <= n_j;  r_pidx <= n_pidx;  r_pv <= n_pv;
        r_found <= n_found;  r_best <= n_best;  r_bbase <= n_bbase;  r_bsize <= n_bsize;
        r_key_base <= n_key_base;  r_key_size <= n_key_size;
        r_cur_base <= n_cur_base;  r_cur_size <= n_cur_size;
        r_w <= n_w;  r_mrg <= n_mrg;
        r_status <= n_status;  r_gbase <= n_gbase;  r_gsize <= n_gsize;
        r_merged <= n_merged;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE) && !i_start;
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_granted_base = r_gbase;
    assign o_granted_size = r_gsize;
    assign o_merged       = r_merged;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C) else $error("entry count exceeds table depth");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_granted_size != '0)) |-> (o_status == ST_OK))
        else $error("grant reported with error status");

    a_merge_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_merged) |-> (o_status == ST_OK))
        else $error("merge flag with error status");

    a_start_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted transaction neither in progress nor reported");

endmodule

FILE: tb/sv/tb_best_fit_free_list_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_fit_free_list_allocator_top
// Self-checking bench for the best-fit allocator. A scoreboard keeps a copy of
// the free table and the pool size, predicts the single result of each
// transaction and compares it with the strobed result. Stimulus is mostly
// alloc/free/reclaim runs with random gaps, plus pool size changes.
// ----------------------------------------------------------------------------
module tb_best_fit_free_list_allocator_top;
    import bffa_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int AB    = DEF_ADDR_BITS;
    localparam int WDOG  = 200000;

    typedef struct packed {
        logic [1:0]    status;
        logic [AB-1:0] gbase;
        logic [AB:0]   gsize;
        logic          merged;
    } alloc_res_t;

    class alloc_scoreboard;
        logic [AB:0]   pool;
        logic [AB-1:0] fbase[DEPTH];
        logic [AB:0]   fsize[DEPTH];
        int            cnt;
        alloc_res_t    pending[$];
        int            errors;
        int            checked;

        function void reload();
            for (int k = 0; k < DEPTH; k++) begin
                fbase[k] = '0;
                fsize[k] = '0;
            end
            fsize[0] = pool;
            cnt = 1;
        endfunction

        function void set_pool(logic [AB:0] v);
            if (v == 0) v = 1;
            if (v > {1'b1, {AB{1'b0}}}) v = {1'b1, {AB{1'b0}}};
            pool = v;
            reload();
        endfunction

        function void drop(int at);
            for (int k = at; k + 1 < cnt; k++) begin
                fbase[k] = fbase[k+1];
                fsize[k] = fsize[k+1];
            end
            cnt--;
        endfunction

        function void note_request(logic [1:0] op, logic [AB:0] req, logic [AB-1:0] ab);
            alloc_res_t r;
            int best;
            int i;
            int j;
            logic [AB-1:0] b;
            logic [AB:0] s;
            r = '0;
            best = -1;
            if (op == OP_ALLOC) begin
                if (req == 0 || req > pool) r.status = ST_BAD_REQ;
                else begin
                    for (i = 0; i < cnt; i++)
                        if (fsize[i] >= req && (best < 0 || fsize[i] < fsize[best]))
                            best = i;
                    if (best < 0) r.status = ST_NO_FIT;
                    else begin
                        r.gbase = fbase[best];
                        r.gsize = req;
                        if (fsize[best] > req) begin
                            fsize[best] = fsize[best] - req;
                            fbase[best] = fbase[best] + req[AB-1:0];
                        end else drop(best);
                    end
                end
            end else if (op == OP_FREE) begin
                if (req == 0 || req > pool) r.status = ST_BAD_REQ;
                else if (cnt >= DEPTH) r.status = ST_FULL;
                else begin
                    fbase[cnt] = ab;
                    fsize[cnt] = req;
                    cnt++;
                end
            end else if (op == OP_RECLAIM) begin
                for (i = 1; i < cnt; i++) begin
                    b = fbase[i];
                    s = fsize[i];
                    j = i;
                    while (j > 0 && fbase[j-1] > b) begin
                        fbase[j] = fbase[j-1];
                        fsize[j] = fsize[j-1];
                        j--;
                    end
                    fbase[j] = b;
                    fsize[j] = s;
                end
                i = 0;
                j = 1;
                while (j < cnt) begin
                    if ({1'b0, fbase[j]} == {1'b0, fbase[i]} + fsize[i]) begin
                        fsize[i] = fsize[i] + fsize[j];
                        drop(j);
                        r.merged = 1'b1;
                    end else begin
                        i = j;
                        j++;
                    end
                end
            end else r.status = ST_BAD_REQ;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(alloc_res_t got);
            alloc_res_t e;
            if (pending.size() == 0) begin
                $error("unexpected result status=%0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.gbase !== e.gbase) begin
                $error("granted_base exp %0h got %0h", e.gbase, got.gbase); errors++;
            end
            if (got.gsize !== e.gsize) begin
                $error("granted_size exp %0h got %0h", e.gsize, got.gsize); errors++;
            end
            if (got.merged !== e.merged) begin
                $error("merged exp %0d got %0d", e.merged, got.merged); errors++;
            end
        endfunction
    endclass

    logic          clk = 0;
    logic          rst_n = 0;
    logic          start = 0;
    logic          busy;
    logic [1:0]    operation = '0;
    logic [AB:0]   req_size = '0;
    logic [AB-1:0] area_base = '0;
    logic          cfg_valid = 0;
    logic          cfg_ready;
    logic [AB:0]   cfg_data = '0;
    logic          done;
    logic [1:0]    status;
    logic [AB-1:0] granted_base;
    logic [AB:0]   granted_size;
    logic          merged;

    alloc_scoreboard sb;
    int idle_cycles;
    int n_alloc, n_free, n_reclaim, n_cfg;

    always #1 clk = ~clk;

    best_fit_free_list_allocator_top u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_operation(operation), .i_req_size(req_size), .i_area_base(area_base),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_done(done), .o_status(status), .o_granted_base(granted_base),
        .o_granted_size(granted_size), .o_merged(merged)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if (done) sb.check_result({status, granted_base, granted_size, merged});
            if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG) begin
                $display("watchdog expired");
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_op(logic [1:0] op, logic [AB:0] req, logic [AB-1:0] ab);
        int gap;
        gap = $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation <= op;
        req_size  <= req;
        area_base <= ab;
        start     <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_request(op, req, ab);
        case (op)
            OP_ALLOC:   n_alloc++;
            OP_FREE:    n_free++;
            OP_RECLAIM: n_reclaim++;
            default:    ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_pool(logic [AB:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_pool(v);
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [AB:0] rand_size(logic [AB:0] pool);
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return (AB+1)'($urandom_range(0, 2 ** (AB + 1) - 1));
        if (m == 1) return pool;
        if (m < 5) return (AB+1)'($urandom_range(1, (pool > 64) ? 64 : pool));
        return (AB+1)'($urandom_range(1, pool));
    endfunction

    task automatic random_phase(int items, logic [AB:0] pool);
        logic [AB:0]   sz;
        logic [AB-1:0] bs;
        int r;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 19);
            sz = rand_size(pool);
            bs = AB'($urandom());
            if (r < 9) send_op(OP_ALLOC, sz, bs);
            else if (r < 17) begin
                if ($urandom_range(0, 1) && sb.cnt > 0) begin
                    // adjacent to an existing area so reclaim joins it
                    bs = sb.fbase[$urandom_range(0, sb.cnt - 1)];
                    bs = bs - sz[AB-1:0];
                end
                send_op(OP_FREE, sz, bs);
            end else if (r < 19) send_op(OP_RECLAIM, sz, bs);
            else send_op(OP_RSVD, sz, bs);
        end
    endtask

    initial begin
        sb = new();
        sb.errors = 0;
        sb.checked = 0;
        sb.set_pool(17'd65536);
        idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes and special cases
        send_op(OP_RECLAIM, '0, '0);
        send_op(OP_ALLOC, '0, '0);
        send_op(OP_ALLOC, 17'd65537, '0);
        send_op(OP_ALLOC, 17'h1FFFF, 16'hFFFF);
        send_op(OP_ALLOC, 17'd65536, '0);
        send_op(OP_ALLOC, 17'd1, '0);
        send_op(OP_RECLAIM, '0, '0);
        send_op(OP_FREE, '0, 16'h10);
        send_op(OP_FREE, 17'd65537, 16'h10);
        send_op(OP_FREE, 17'd256, 16'h100);
        send_op(OP_FREE, 17'd256, 16'h0);
        send_op(OP_FREE, 17'd16, 16'hFFF0);
        send_op(OP_ALLOC, 17'd16, '0);
        send_op(OP_ALLOC, 17'd100, '0);
        send_op(OP_RSVD, 17'h1FFFF, 16'hFFFF);
        send_op(OP_RECLAIM, '0, '0);
        for (int k = 0; k < 66; k++) send_op(OP_FREE, 17'd1, k[AB-1:0]);
        send_op(OP_RECLAIM, '0, '0);
        send_op(OP_ALLOC, 17'd64, '0);

        write_pool(17'd65536);
        random_phase(170, 17'd65536);
        write_pool(17'd0);
        send_op(OP_ALLOC, 17'd1, '0);
        send_op(OP_ALLOC, 17'd1, '0);
        random_phase(60, 17'd1);
        write_pool(17'h1FFFF);
        random_phase(100, 17'd65536);
        write_pool(17'd300);
        random_phase(124, 17'd300);
        write_pool(17'h0ABCD);
        random_phase(100, 17'h0ABCD);

        drain();
        $display("covered %0d alloc, %0d free, %0d reclaim transactions, %0d pool writes",
                 n_alloc, n_free, n_reclaim, n_cfg);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/bffa_pkg.sv
hdl/best_fit_free_list_allocator_top.sv
tb/sv/tb_best_fit_free_list_allocator_top.sv
